### hdl/crc_checked_update_frame_receiver_macros.svh
// Assertion helpers used by the asserting module, cufr_back.
// Both expect clk and arst_n in scope.
`ifndef CRC_CHECKED_UPDATE_FRAME_RECEIVER_MACROS_SVH
`define CRC_CHECKED_UPDATE_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication.
`define CUFR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CUFR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/cufr_pkg.sv
package cufr_pkg;

	// Frame framing bytes
	localparam logic [7:0]  HDR1_BYTE = 8'h55;
	localparam logic [7:0]  HDR2_BYTE = 8'hAA;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] START_LEN = 16'd4;

	// Register indexes
	localparam logic [2:0] REG_START = 3'd0;
	localparam logic [2:0] REG_DATA  = 3'd1;
	localparam logic [2:0] REG_END   = 3'd2;
	localparam logic [2:0] REG_ABORT = 3'd3;
	localparam logic [2:0] REG_ACK   = 3'd4;
	localparam logic [2:0] REG_NAK   = 3'd5;

	// Register reset values
	localparam logic [7:0] RST_START = 8'd1;
	localparam logic [7:0] RST_DATA  = 8'd2;
	localparam logic [7:0] RST_END   = 8'd3;
	localparam logic [7:0] RST_ABORT = 8'd4;
	localparam logic [7:0] RST_ACK   = 8'd6;
	localparam logic [7:0] RST_NAK   = 8'd21;

	typedef enum logic [2:0] {
		PH_HDR1, PH_HDR2, PH_CMD, PH_LENH, PH_LENL, PH_DATA, PH_CRCH, PH_CRCL
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK, ST_CRC, ST_LEN, ST_NOSESS, ST_CMD
	} status_t;

	typedef enum logic [2:0] {
		KIND_START, KIND_DATA, KIND_END, KIND_ABORT, KIND_OTHER
	} kind_t;

	typedef struct packed {
		logic [7:0] start_code;
		logic [7:0] data_code;
		logic [7:0] end_code;
		logic [7:0] abort_code;
		logic [7:0] ack_code;
		logic [7:0] nak_code;
	} cfg_t;

	// One parsed frame, handed from parser to verdict unit
	typedef struct packed {
		logic [7:0]  cmd;
		logic [15:0] len;
		logic        crc_ok;
		logic [31:0] size;
	} frame_t;

	typedef struct packed {
		logic [7:0]  reply;
		status_t     status;
		kind_t       kind;
		logic [10:0] plen;
		logic [31:0] offset;
		logic [31:0] stored_size;
		logic        open;
		logic        complete;
	} result_t;

	// CRC16-CCITT, MSB first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

### hdl/cufr_front.sv
module cufr_front #(
	parameter int MAX_PAYLOAD = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	output logic              frame_push,
	output cufr_pkg::frame_t  frame
);

	localparam int IW = $clog2(MAX_PAYLOAD + 1);

	cufr_pkg::phase_t phase_q, phase_d;
	logic [7:0]    cmd_q;
	logic [15:0]   len_q;
	logic [IW-1:0] idx_q;
	logic [15:0]   crc_q;
	logic [7:0]    rch_q;
	logic [31:0]   size_q;

	logic [15:0] len_full;
	logic [16:0] idx_inc;
	logic        data_last;

	assign len_full  = {len_q[15:8], rx_byte};
	assign idx_inc   = 17'(idx_q) + 17'd1;
	assign data_last = idx_inc >= {1'b0, len_q};

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cufr_pkg::PH_HDR1;
		end else if (accept) begin
			phase_q <= phase_d;
		end
	end

	// Next phase and frame hand-off
	always_comb begin
		phase_d    = phase_q;
		frame_push = 1'b0;
		case (phase_q)
			cufr_pkg::PH_HDR1: if (rx_byte == cufr_pkg::HDR1_BYTE) phase_d = cufr_pkg::PH_HDR2;
			cufr_pkg::PH_HDR2: begin
				phase_d = (rx_byte == cufr_pkg::HDR2_BYTE) ? cufr_pkg::PH_CMD : cufr_pkg::PH_HDR1;
			end
			cufr_pkg::PH_CMD:  phase_d = cufr_pkg::PH_LENH;
			cufr_pkg::PH_LENH: phase_d = cufr_pkg::PH_LENL;
			cufr_pkg::PH_LENL: begin
				if (len_full == 16'd0) phase_d = cufr_pkg::PH_CRCH;
				else if ({1'b0, len_full} <= 17'(MAX_PAYLOAD)) phase_d = cufr_pkg::PH_DATA;
				else phase_d = cufr_pkg::PH_HDR1;
			end
			cufr_pkg::PH_DATA: if (data_last) phase_d = cufr_pkg::PH_CRCH;
			cufr_pkg::PH_CRCH: phase_d = cufr_pkg::PH_CRCL;
			cufr_pkg::PH_CRCL: begin
				phase_d    = cufr_pkg::PH_HDR1;
				frame_push = accept;
			end
			default: phase_d = cufr_pkg::PH_HDR1;
		endcase
	end

	// Field capture, running CRC, first payload word
	always_ff @(posedge clk) begin
		if (accept) begin
			case (phase_q)
				cufr_pkg::PH_CMD:  cmd_q <= rx_byte;
				cufr_pkg::PH_LENH: len_q <= {rx_byte, 8'h00};
				cufr_pkg::PH_LENL: begin
					len_q <= len_full;
					idx_q <= '0;
					crc_q <= cufr_pkg::CRC_INIT;
				end
				cufr_pkg::PH_DATA: begin
					if (idx_q < IW'(4)) size_q[{idx_q[1:0], 3'b000} +: 8] <= rx_byte;
					crc_q <= cufr_pkg::crc16_byte(crc_q, rx_byte);
					idx_q <= idx_inc[IW-1:0];
				end
				cufr_pkg::PH_CRCH: rch_q <= rx_byte;
				default: ;
			endcase
		end
	end

	assign frame.cmd    = cmd_q;
	assign frame.len    = len_q;
	assign frame.crc_ok = (crc_q == {rch_q, rx_byte});
	assign frame.size   = size_q;

endmodule

### hdl/cufr_fifo.sv
module cufr_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cufr_pkg::frame_t  wdata,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output cufr_pkg::frame_t  rdata
);

	cufr_pkg::frame_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) wr_ptr_q <= ~wr_ptr_q;
			if (pop && !empty) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

### hdl/cufr_back.sv
`include "crc_checked_update_frame_receiver_macros.svh"

module cufr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cufr_pkg::cfg_t    cfg,
	input  logic              frame_valid,
	input  cufr_pkg::frame_t  frame,
	output logic              frame_take,
	output logic              res_valid,
	input  logic              res_pop,
	output cufr_pkg::result_t res
);

	logic        open_q, comp_q;
	logic [31:0] bw_q, img_q;
	logic        out_v_q;
	cufr_pkg::result_t res_q;

	cufr_pkg::kind_t   kind;
	cufr_pkg::status_t status;
	logic        open_n, comp_n;
	logic [31:0] bw_n, img_n, offset;
	cufr_pkg::result_t res_n;

	assign frame_take = frame_valid && (!out_v_q || res_pop);
	assign res_valid  = out_v_q;
	assign res        = res_q;

	// Verdict and session update
	always_comb begin
		if (frame.cmd == cfg.start_code) kind = cufr_pkg::KIND_START;
		else if (frame.cmd == cfg.data_code) kind = cufr_pkg::KIND_DATA;
		else if (frame.cmd == cfg.end_code) kind = cufr_pkg::KIND_END;
		else if (frame.cmd == cfg.abort_code) kind = cufr_pkg::KIND_ABORT;
		else kind = cufr_pkg::KIND_OTHER;

		status = cufr_pkg::ST_OK;
		open_n = open_q;
		comp_n = comp_q;
		bw_n   = bw_q;
		img_n  = img_q;
		if (!frame.crc_ok) begin
			status = cufr_pkg::ST_CRC;
		end else begin
			case (kind)
				cufr_pkg::KIND_START: begin
					if (frame.len != cufr_pkg::START_LEN) begin
						status = cufr_pkg::ST_LEN;
					end else begin
						img_n  = frame.size;
						open_n = 1'b1;
						comp_n = 1'b0;
						bw_n   = '0;
					end
				end
				cufr_pkg::KIND_DATA: begin
					if (!open_q) status = cufr_pkg::ST_NOSESS;
					else bw_n = bw_q + 32'(frame.len);
				end
				cufr_pkg::KIND_END: begin
					if (!open_q) begin
						status = cufr_pkg::ST_NOSESS;
					end else begin
						comp_n = 1'b1;
						open_n = 1'b0;
					end
				end
				cufr_pkg::KIND_ABORT: begin
					open_n = 1'b0;
					comp_n = 1'b0;
					bw_n   = '0;
					img_n  = '0;
				end
				default: status = cufr_pkg::ST_CMD;
			endcase
		end

		// accepted data reports the offset before it advances
		offset = (kind == cufr_pkg::KIND_DATA && status == cufr_pkg::ST_OK) ? bw_q : bw_n;

		res_n.reply       = (status == cufr_pkg::ST_OK) ? cfg.ack_code : cfg.nak_code;
		res_n.status      = status;
		res_n.kind        = kind;
		res_n.plen        = frame.len[10:0];
		res_n.offset      = offset;
		res_n.stored_size = img_n;
		res_n.open        = open_n;
		res_n.complete    = comp_n;
	end

	// Session state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			comp_q  <= 1'b0;
			bw_q    <= '0;
			img_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (frame_take) begin
				open_q  <= open_n;
				comp_q  <= comp_n;
				bw_q    <= bw_n;
				img_q   <= img_n;
				out_v_q <= 1'b1;
			end else if (res_pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) res_q <= res_n;
	end

	`CUFR_ASSERT_IMP(a_open_xor_comp, 1'b1, !(open_q && comp_q), "session open and complete")
	`CUFR_ASSERT_NXT(a_take_shows, frame_take, out_v_q, "taken frame gave no result")
	`CUFR_ASSERT_IMP(a_ok_is_ack, out_v_q && res_q.status == cufr_pkg::ST_OK,
		res_q.reply == cfg.ack_code, "ok verdict without ack")
	`CUFR_ASSERT_IMP(a_start_offset, out_v_q && res_q.status == cufr_pkg::ST_OK &&
		res_q.kind == cufr_pkg::KIND_START, res_q.offset == 32'd0 && res_q.open,
		"accepted start left offset or session wrong")

endmodule

### hdl/crc_checked_update_frame_receiver.sv
// Update-frame receiver: takes one received byte per cycle, finds frames of
// 55 AA, command, length (big-endian), payload, CRC16-CCITT (big-endian), and
// gives one verdict item per complete frame; the item passes through the frame
// queue and then the verdict unit's result register before it can be popped.
// The parser accepts a byte every
// cycle; it only holds off (full high) while two parsed frames wait in the
// queue in front of the verdict unit because the result has not been popped.
// Frames longer than MAX_PAYLOAD are dropped silently. Command and reply codes must
// be written through the cfg port only while no frame is in flight; the block does not enforce this.
module crc_checked_update_frame_receiver #(
	parameter int MAX_PAYLOAD = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  reply_byte,
	output logic [2:0]  frame_status,
	output logic [2:0]  frame_kind,
	output logic [10:0] payload_length,
	output logic [31:0] write_offset,
	output logic [31:0] stored_size,
	output logic        session_open,
	output logic        session_complete,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cufr_pkg::cfg_t    cfg_q;
	cufr_pkg::frame_t  fr_in, fr_head;
	cufr_pkg::result_t res;
	logic q_push, q_empty, q_take, res_valid;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code <= cufr_pkg::RST_START;
			cfg_q.data_code  <= cufr_pkg::RST_DATA;
			cfg_q.end_code   <= cufr_pkg::RST_END;
			cfg_q.abort_code <= cufr_pkg::RST_ABORT;
			cfg_q.ack_code   <= cufr_pkg::RST_ACK;
			cfg_q.nak_code   <= cufr_pkg::RST_NAK;
		end else if (cfg_write) begin
			case (cfg_index)
				cufr_pkg::REG_START: cfg_q.start_code <= cfg_data;
				cufr_pkg::REG_DATA:  cfg_q.data_code  <= cfg_data;
				cufr_pkg::REG_END:   cfg_q.end_code   <= cfg_data;
				cufr_pkg::REG_ABORT: cfg_q.abort_code <= cfg_data;
				cufr_pkg::REG_ACK:   cfg_q.ack_code   <= cfg_data;
				cufr_pkg::REG_NAK:   cfg_q.nak_code   <= cfg_data;
				default: ;
			endcase
		end
	end

	cufr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (push && !full),
		.rx_byte    (rx_byte),
		.frame_push (q_push),
		.frame      (fr_in)
	);

	cufr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (fr_in),
		.full   (full),
		.pop    (q_take),
		.empty  (q_empty),
		.rdata  (fr_head)
	);

	cufr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.frame_valid (!q_empty),
		.frame       (fr_head),
		.frame_take  (q_take),
		.res_valid   (res_valid),
		.res_pop     (pop),
		.res         (res)
	);

	assign empty            = !res_valid;
	assign reply_byte       = res.reply;
	assign frame_status     = res.status;
	assign frame_kind       = res.kind;
	assign payload_length   = res.plen;
	assign write_offset     = res.offset;
	assign stored_size      = res.stored_size;
	assign session_open     = res.open;
	assign session_complete = res.complete;

endmodule

### tb/cufr_verdict_checker.sv
`timescale 1ns / 100ps

// Watches the byte, result and register channels, predicts each frame verdict
// and compares it with what the block pops.
module cufr_verdict_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  reply_byte,
	input  logic [2:0]  frame_status,
	input  logic [2:0]  frame_kind,
	input  logic [10:0] payload_length,
	input  logic [31:0] write_offset,
	input  logic [31:0] stored_size,
	input  logic        session_open,
	input  logic        session_complete,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          mismatches,
	output int          verdicts_waiting,
	output int          verdicts_checked,
	output logic        in_frame
);

	localparam int STORE_DEPTH = 1024;

	// mirrored registers and frame state
	cufr_pkg::cfg_t    codes;
	cufr_pkg::phase_t  phase;
	logic [7:0]  cmd;
	logic [15:0] flen;
	int unsigned pidx;
	logic [15:0] got_crc;
	logic [15:0] run_crc;
	logic [7:0]  store [STORE_DEPTH];
	logic        sess_open;
	logic        sess_done;
	logic [31:0] img_size;
	logic [31:0] written;
	cufr_pkg::result_t verdict_q[$];

	assign in_frame = (phase != cufr_pkg::PH_HDR1);

	function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        msb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			msb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (msb) c = c ^ 16'h1021;
		end
		return c;
	endfunction

	task automatic clear_session();
		phase = cufr_pkg::PH_HDR1;
		cmd = '0;
		flen = '0;
		pidx = 0;
		got_crc = '0;
		run_crc = 16'hFFFF;
		sess_open = 1'b0;
		sess_done = 1'b0;
		img_size = '0;
		written = '0;
	endtask

	// verdict at the last CRC byte
	task automatic settle_frame();
		cufr_pkg::result_t r;
		logic    ok;
		ok = 1'b1;
		r.status = cufr_pkg::ST_OK;
		if (cmd == codes.start_code) r.kind = cufr_pkg::KIND_START;
		else if (cmd == codes.data_code) r.kind = cufr_pkg::KIND_DATA;
		else if (cmd == codes.end_code) r.kind = cufr_pkg::KIND_END;
		else if (cmd == codes.abort_code) r.kind = cufr_pkg::KIND_ABORT;
		else r.kind = cufr_pkg::KIND_OTHER;
		r.plen = flen[10:0];
		r.offset = written;
		if (run_crc != got_crc) begin
			r.status = cufr_pkg::ST_CRC;
			ok = 1'b0;
		end else begin
			case (r.kind)
				cufr_pkg::KIND_START: begin
					if (flen != 16'd4) begin
						r.status = cufr_pkg::ST_LEN;
						ok = 1'b0;
					end else begin
						img_size = {store[3], store[2], store[1], store[0]};
						sess_open = 1'b1;
						sess_done = 1'b0;
						written = '0;
						r.offset = '0;
					end
				end
				cufr_pkg::KIND_DATA, cufr_pkg::KIND_END: begin
					if (!sess_open) begin
						r.status = cufr_pkg::ST_NOSESS;
						ok = 1'b0;
					end else if (r.kind == cufr_pkg::KIND_DATA) begin
						written = written + 32'(flen);
					end else begin
						sess_done = 1'b1;
						sess_open = 1'b0;
					end
				end
				cufr_pkg::KIND_ABORT: begin
					clear_session();
					r.offset = '0;
				end
				default: begin
					r.status = cufr_pkg::ST_CMD;
					ok = 1'b0;
				end
			endcase
		end
		r.reply = ok ? codes.ack_code : codes.nak_code;
		r.stored_size = img_size;
		r.open = sess_open;
		r.complete = sess_done;
		verdict_q.push_back(r);
	endtask

	task automatic take_byte(input logic [7:0] b);
		case (phase)
			cufr_pkg::PH_HDR1: if (b == 8'h55) phase = cufr_pkg::PH_HDR2;
			cufr_pkg::PH_HDR2: phase = (b == 8'hAA) ? cufr_pkg::PH_CMD : cufr_pkg::PH_HDR1;
			cufr_pkg::PH_CMD: begin
				cmd = b;
				phase = cufr_pkg::PH_LENH;
			end
			cufr_pkg::PH_LENH: begin
				flen = {b, 8'h00};
				phase = cufr_pkg::PH_LENL;
			end
			cufr_pkg::PH_LENL: begin
				flen = {flen[15:8], b};
				pidx = 0;
				run_crc = 16'hFFFF;
				if (flen == 0) phase = cufr_pkg::PH_CRCH;
				else if (flen <= STORE_DEPTH) phase = cufr_pkg::PH_DATA;
				else phase = cufr_pkg::PH_HDR1;
			end
			cufr_pkg::PH_DATA: begin
				store[pidx] = b;
				run_crc = crc_next(run_crc, b);
				pidx++;
				if (pidx >= flen) phase = cufr_pkg::PH_CRCH;
			end
			cufr_pkg::PH_CRCH: begin
				got_crc = {b, 8'h00};
				phase = cufr_pkg::PH_CRCL;
			end
			default: begin
				got_crc = {got_crc[15:8], b};
				phase = cufr_pkg::PH_HDR1;
				settle_frame();
			end
		endcase
	endtask

	task automatic check_verdict();
		cufr_pkg::result_t want;
		logic [7:0] diff;
		if (verdict_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected verdict reply=%h status=%0d kind=%0d",
					$realtime, reply_byte, frame_status, frame_kind);
			return;
		end
		want = verdict_q.pop_front();
		verdicts_checked++;
		diff = {reply_byte != want.reply, frame_status != want.status,
			frame_kind != want.kind, payload_length != want.plen,
			write_offset != want.offset, stored_size != want.stored_size,
			session_open != want.open, session_complete != want.complete};
		if (diff != 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: verdict %0d differs (field flags %b)", $realtime,
					verdicts_checked, diff);
				$display("  expected reply=%h st=%0d kind=%0d len=%0d off=%h size=%h o=%b c=%b",
					want.reply, want.status, want.kind, want.plen, want.offset,
					want.stored_size, want.open, want.complete);
				$display("  actual   reply=%h st=%0d kind=%0d len=%0d off=%h size=%h o=%b c=%b",
					reply_byte, frame_status, frame_kind, payload_length, write_offset,
					stored_size, session_open, session_complete);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes = '{cufr_pkg::RST_START, cufr_pkg::RST_DATA, cufr_pkg::RST_END,
				cufr_pkg::RST_ABORT, cufr_pkg::RST_ACK, cufr_pkg::RST_NAK};
			clear_session();
			verdict_q.delete();
			mismatches = 0;
			verdicts_checked = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					cufr_pkg::REG_START: codes.start_code = cfg_data;
					cufr_pkg::REG_DATA:  codes.data_code = cfg_data;
					cufr_pkg::REG_END:   codes.end_code = cfg_data;
					cufr_pkg::REG_ABORT: codes.abort_code = cfg_data;
					cufr_pkg::REG_ACK:   codes.ack_code = cfg_data;
					cufr_pkg::REG_NAK:   codes.nak_code = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty) check_verdict();
			if (push && !full) take_byte(rx_byte);
		end
		verdicts_waiting = verdict_q.size();
	end

endmodule

### tb/crc_checked_update_frame_receiver_tb.sv
`timescale 1ns / 100ps

module crc_checked_update_frame_receiver_tb;

	localparam int BYTE_GOAL = 1950;
	localparam int STALL_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  rx_byte;
	logic        empty;
	logic        pop;
	logic [7:0]  reply_byte;
	logic [2:0]  frame_status;
	logic [2:0]  frame_kind;
	logic [10:0] payload_length;
	logic [31:0] write_offset;
	logic [31:0] stored_size;
	logic        session_open;
	logic        session_complete;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	int   mismatches;
	int   verdicts_waiting;
	int   verdicts_checked;
	logic in_frame;
	int   bytes_sent;
	int   stall_cycles;
	bit   calm;
	logic [7:0] code [6];

	crc_checked_update_frame_receiver dut (.*);

	cufr_verdict_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// result side: random pop stalls except in the calm stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= calm || ($urandom_range(0, 99) >= 7);
		end
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles > STALL_LIMIT) begin
				$display("no progress for %0d cycles", STALL_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// one byte, with a random idle cycle ahead of it
	task automatic put(input logic [7:0] b);
		if (!calm && $urandom_range(0, 99) < 7) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] c, input int len, input bit bad_crc,
			input logic [31:0] word);
		logic [15:0] crc;
		logic [7:0]  b;
		crc = cufr_pkg::CRC_INIT;
		put(cufr_pkg::HDR1_BYTE);
		put(cufr_pkg::HDR2_BYTE);
		put(c);
		put(len[15:8]);
		put(len[7:0]);
		if (len > 1024) return;
		for (int i = 0; i < len; i++) begin
			b = (i < 4) ? word[8*i +: 8] : 8'($urandom);
			crc = cufr_pkg::crc16_byte(crc, b);
			put(b);
		end
		if (bad_crc) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
		put(crc[15:8]);
		put(crc[7:0]);
	endtask

	// finish any open frame and wait until every verdict is popped;
	// checker state is read at the falling edge, after it has settled
	task automatic drain();
		push <= 1'b0;
		@(negedge clk);
		while (in_frame) begin
			@(posedge clk);
			put(8'h00);
			push <= 1'b0;
			@(negedge clk);
		end
		while (verdicts_waiting != 0) @(negedge clk);
	endtask

	// drain the parser and the result queue, then rewrite every register
	task automatic load_codes(input logic [7:0] v [6]);
		drain();
		repeat (10) @(posedge clk);
		for (int i = 0; i < 6; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= v[i];
			code[i] = v[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return $urandom_range(25, 1024);
		if (r < 6) return 1024;
		return $urandom_range(0, 24);
	endfunction

	task automatic random_episode();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			// session of start, data and optional end frames, random content, occasional bad CRC
			send_frame(code[cufr_pkg::REG_START], 4, $urandom_range(0, 99) < 8, $urandom);
			n = $urandom_range(0, 4);
			for (int i = 0; i < n; i++)
				send_frame(code[cufr_pkg::REG_DATA], pick_len(), $urandom_range(0, 99) < 8,
					$urandom);
			if ($urandom_range(0, 3) != 0)
				send_frame(code[cufr_pkg::REG_END], $urandom_range(0, 3),
					$urandom_range(0, 99) < 8, $urandom);
		end else if (r < 70) begin
			send_frame($urandom_range(0, 1) ? code[$urandom_range(0, 3)] : 8'($urandom),
				$urandom_range(0, 8), $urandom_range(0, 99) < 10, $urandom);
		end else if (r < 78) begin
			send_frame(code[cufr_pkg::REG_ABORT], $urandom_range(0, 6), 1'b0, $urandom);
		end else if (r < 86) begin
			// oversize length: dropped, trailing junk
			send_frame(8'($urandom), $urandom_range(1025, 65535), 1'b0, '0);
			repeat ($urandom_range(0, 3)) put(8'($urandom));
		end else begin
			// broken header or plain noise
			if ($urandom_range(0, 1)) put(cufr_pkg::HDR1_BYTE);
			repeat ($urandom_range(1, 6)) put(8'($urandom));
		end
	endtask

	logic [7:0] setting [6];

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		rx_byte = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		bytes_sent = 0;
		stall_cycles = 0;
		code = '{cufr_pkg::RST_START, cufr_pkg::RST_DATA, cufr_pkg::RST_END,
			cufr_pkg::RST_ABORT, cufr_pkg::RST_ACK, cufr_pkg::RST_NAK};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: session flow, each verdict status, header oddities
		send_frame(code[cufr_pkg::REG_DATA], 0, 1'b0, '0);
		send_frame(code[cufr_pkg::REG_START], 4, 1'b0, 32'hFFFF_FFFF);
		send_frame(code[cufr_pkg::REG_DATA], 0, 1'b0, '0);
		send_frame(code[cufr_pkg::REG_DATA], 2, 1'b1, '0);
		send_frame(code[cufr_pkg::REG_END], 0, 1'b0, '0);
		send_frame(code[cufr_pkg::REG_START], 0, 1'b0, '0);
		send_frame(8'hFF, 1, 1'b0, '0);
		put(cufr_pkg::HDR1_BYTE);
		put(cufr_pkg::HDR1_BYTE);
		put(cufr_pkg::HDR2_BYTE);
		send_frame(8'h00, 16'hFFFF, 1'b0, '0);
		send_frame(code[cufr_pkg::REG_ABORT], 0, 1'b0, '0);

		// random phases under several register settings
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: setting = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd255, 8'd0};
				1: setting = '{8'd7, 8'd7, 8'd9, 8'd7, 8'hA5, 8'h5A};
				2: for (int i = 0; i < 6; i++) setting[i] = 8'($urandom);
				default: setting = '{cufr_pkg::RST_START, cufr_pkg::RST_DATA,
					cufr_pkg::RST_END, cufr_pkg::RST_ABORT, cufr_pkg::RST_ACK,
					cufr_pkg::RST_NAK};
			endcase
			load_codes(setting);
			calm = (ph == 2);
			while (bytes_sent < (ph + 1) * BYTE_GOAL / 4) random_episode();
			calm = 1'b0;
		end

		drain();
		repeat (20) @(posedge clk);
		$display("sent %0d bytes over four register settings, %0d frame verdicts checked",
			bytes_sent, verdicts_checked);
		$display("sessions, bad CRC, bad start length, no session, unknown and oversize frames");
		if (mismatches == 0 && verdicts_waiting == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
